// ===== rtl/buddy_tree_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// buddy_tree_allocator_defines
// assertion macros shared by the allocator modules
// ----------------------------------------------------------------------------
`ifndef BUDDY_TREE_ALLOCATOR_DEFINES_SVH
`define BUDDY_TREE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define BTA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define BTA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// bta_pkg
// constants, types and helper functions of the buddy tree allocator
// ----------------------------------------------------------------------------
package bta_pkg;

   // geometry: leaves of 64 bytes, 14 levels below the root
   localparam int LEAF_SHIFT   = 6;
   localparam int TREE_LEVELS  = 14;
   localparam int REGION_SHIFT = LEAF_SHIFT + TREE_LEVELS;
   localparam int NODE_COUNT   = (2 << TREE_LEVELS) - 1;

   // field and index widths
   localparam int ADDR_W = 48;
   localparam int SIZE_W = 21;
   localparam int LVL_W  = $clog2(TREE_LEVELS + 1);
   localparam int POS_W  = TREE_LEVELS;
   localparam int IDX_W  = TREE_LEVELS + 1;

   // controller states
   typedef enum logic [3:0] {
      ST_CLR_INIT,
      ST_CLR_SWEEP,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SWEEP,
      ST_UP,
      ST_SIB_CHK,
      ST_DONE_OK,
      ST_DONE_FAIL
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic latch;
      logic scan_init;
      logic scan_rd;
      logic scan_next;
      logic hit;
      logic clr_init;
      logic sweep_step;
      logic sib_rd;
      logic up_step;
      logic load_rsp;
      logic rsp_ok;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic op_free;
      logic size_fail;
      logic addr_fail;
      logic match;
      logic scan_last;
      logic sweep_last;
      logic up_top;
      logic sib_free;
      logic rsp_busy;
   } stat_type;

   // heap index of a node from its level and position in the level
   function automatic logic [IDX_W-1:0] node_index(input logic [LVL_W-1:0] lvl,
                                                   input logic [POS_W-1:0] pos);
      node_index = IDX_W'((1 << lvl) - 1) + IDX_W'(pos);
   endfunction

   // deepest level whose block still holds the request
   function automatic logic [LVL_W-1:0] target_depth(input logic [SIZE_W-1:0] size);
      logic [LVL_W-1:0] depth;
      depth = '0;
      for (int d = 0; d <= TREE_LEVELS; d++) begin
         if ((SIZE_W'(1) << (REGION_SHIFT - d)) >= size) begin
            depth = LVL_W'(d);
         end
      end
      target_depth = depth;
   endfunction

endpackage

// ===== rtl/bta_ctrl.sv =====
// ----------------------------------------------------------------------------
// bta_ctrl
// sequencer of the allocator: clearing pass, scan, subtree sweep, path walk
// ----------------------------------------------------------------------------
`include "buddy_tree_allocator_defines.svh"

module bta_ctrl import bta_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLR_INIT:  state_in = ST_CLR_SWEEP;
         ST_CLR_SWEEP: if (stat.sweep_last) state_in = ST_IDLE;
         ST_IDLE:      if (req_valid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (stat.op_free ? stat.addr_fail : stat.size_fail) begin
               state_in = ST_DONE_FAIL;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD:   state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            priority if (stat.match) state_in = ST_SWEEP;
            else if (stat.scan_last) state_in = ST_DONE_FAIL;
            else state_in = ST_SCAN_RD;
         end
         ST_SWEEP:     if (stat.sweep_last) state_in = ST_UP;
         ST_UP: begin
            priority if (stat.up_top) state_in = ST_DONE_OK;
            else if (stat.op_free) state_in = ST_SIB_CHK;
            else state_in = ST_UP;
         end
         ST_SIB_CHK:   state_in = stat.sib_free ? ST_UP : ST_DONE_OK;
         ST_DONE_OK:   if (!stat.rsp_busy) state_in = ST_IDLE;
         ST_DONE_FAIL: if (!stat.rsp_busy) state_in = ST_IDLE;
         default:      state_in = ST_CLR_INIT;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLR_INIT:  cmd.clr_init = 1'b1;
         ST_CLR_SWEEP: cmd.sweep_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         ST_CHECK:     cmd.scan_init = !(stat.op_free ? stat.addr_fail : stat.size_fail);
         ST_SCAN_RD:   cmd.scan_rd = 1'b1;
         ST_SCAN_CHK: begin
            cmd.hit       = stat.match;
            cmd.scan_next = !stat.match && !stat.scan_last;
         end
         ST_SWEEP:     cmd.sweep_step = 1'b1;
         ST_UP: begin
            cmd.sib_rd  = !stat.up_top && stat.op_free;
            cmd.up_step = !stat.up_top && !stat.op_free;
         end
         ST_SIB_CHK:   cmd.up_step = stat.sib_free;
         ST_DONE_OK: begin
            cmd.load_rsp = !stat.rsp_busy;
            cmd.rsp_ok   = 1'b1;
         end
         ST_DONE_FAIL: cmd.load_rsp = !stat.rsp_busy;
         default:      cmd = '0;
      endcase
   end

   // checks on the sequencer
   `BTA_ASSERT_NXT(a_accept_to_check, clock, reset, state_ff == ST_IDLE && req_valid, state_ff == ST_CHECK, "accepted transaction did not move to check")
   `BTA_ASSERT_IMP(a_ready_only_idle, clock, reset, req_ready, state_ff == ST_IDLE, "ready outside idle")
   `BTA_ASSERT_IMP(a_latch_on_accept, clock, reset, cmd.latch, req_valid && req_ready, "capture without an accepted transaction")

endmodule

// ===== rtl/bta_datapath.sv =====
// ----------------------------------------------------------------------------
// bta_datapath
// tree bit stores, scan / sweep / path registers, config and result register
// ----------------------------------------------------------------------------
`include "buddy_tree_allocator_defines.svh"

module bta_datapath import bta_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic              csr_wr_en,
   input  logic [ADDR_W-1:0] csr_wr_data,
   input  logic              req_op,
   input  logic [SIZE_W-1:0] req_request_bytes,
   input  logic [ADDR_W-1:0] req_block_address,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_result_address,
   output logic              rsp_success
);

   // tree stores
   logic nf_mem [NODE_COUNT];
   logic ah_mem [NODE_COUNT];
   logic nf_rd_ff, ah_rd_ff;

   // request registers
   logic [ADDR_W-1:0] base_ff;
   logic              op_ff;
   logic              size_fail_ff;
   logic [LVL_W-1:0]  tdepth_ff;
   logic [ADDR_W-1:0] diff_ff;

   // scan position
   logic [LVL_W-1:0] cur_lvl_ff, cur_lvl_in;
   logic [POS_W-1:0] cur_k_ff, cur_k_in;

   // subtree sweep
   logic [LVL_W-1:0] sw_lvl_ff;
   logic [POS_W-1:0] sw_pos_ff, sw_start_ff, sw_end_ff;
   logic             sw_val_ff, sw_clr_ff;

   // path walk toward the root
   logic [LVL_W-1:0] up_lvl_ff;
   logic [POS_W-1:0] up_k_ff;
   logic             up_val_ff;

   // result register
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic              rsp_ok_ff;

   logic [IDX_W-1:0] cur_idx, sw_idx, par_idx, sib_idx, rd_idx, nf_waddr, ah_waddr;
   logic             nf_we, nf_wdata, ah_we, ah_wdata, aligned;
   logic [ADDR_W-1:0] alloc_addr;

   assign cur_idx = node_index(cur_lvl_ff, cur_k_ff);
   assign sw_idx  = node_index(sw_lvl_ff, sw_pos_ff);
   assign par_idx = node_index(up_lvl_ff - LVL_W'(1), up_k_ff >> 1);
   assign sib_idx = node_index(up_lvl_ff, up_k_ff ^ POS_W'(1));
   assign rd_idx  = cmd.scan_rd ? cur_idx : sib_idx;

   // free address must sit on a block boundary of the candidate level
   assign aligned = (diff_ff[REGION_SHIFT-1:0]
                     & REGION_SHIFT'((1 << (REGION_SHIFT - cur_lvl_ff)) - 1)) == '0;

   assign alloc_addr = ADDR_W'(base_ff + (ADDR_W'(cur_k_ff) << (REGION_SHIFT - cur_lvl_ff)));

   // write port selection
   always_comb begin
      nf_we    = cmd.sweep_step || cmd.up_step;
      nf_waddr = cmd.sweep_step ? sw_idx : par_idx;
      nf_wdata = cmd.sweep_step ? sw_val_ff : up_val_ff;
      ah_we    = cmd.hit || (cmd.sweep_step && sw_clr_ff);
      ah_waddr = cmd.hit ? cur_idx : sw_idx;
      ah_wdata = cmd.hit ? !op_ff : 1'b0;
   end

   // memories, registered read
   always_ff @(posedge clock) begin
      if (nf_we) begin
         nf_mem[nf_waddr] <= nf_wdata;
      end
      if (ah_we) begin
         ah_mem[ah_waddr] <= ah_wdata;
      end
      if (cmd.scan_rd || cmd.sib_rd) begin
         nf_rd_ff <= nf_mem[rd_idx];
         ah_rd_ff <= ah_mem[rd_idx];
      end
   end

   // region base register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff        <= req_op;
         size_fail_ff <= req_request_bytes > SIZE_W'(1 << REGION_SHIFT);
         tdepth_ff    <= target_depth(req_request_bytes);
         diff_ff      <= req_block_address - base_ff;
      end
   end

   // scan position next value
   always_comb begin
      cur_lvl_in = cur_lvl_ff;
      cur_k_in   = cur_k_ff;
      if (cmd.scan_init) begin
         cur_lvl_in = op_ff ? '0 : tdepth_ff;
         cur_k_in   = '0;
      end else if (cmd.scan_next) begin
         if (op_ff) begin
            cur_lvl_in = cur_lvl_ff + LVL_W'(1);
            cur_k_in   = POS_W'(diff_ff[REGION_SHIFT-1:0]
                                >> (REGION_SHIFT - cur_lvl_ff - 1));
         end else begin
            cur_k_in = cur_k_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_lvl_ff <= cur_lvl_in;
      cur_k_ff   <= cur_k_in;
   end

   // subtree sweep, level by level
   always_ff @(posedge clock) begin
      if (cmd.clr_init || cmd.hit) begin
         sw_lvl_ff   <= cmd.clr_init ? '0 : cur_lvl_ff;
         sw_pos_ff   <= cmd.clr_init ? '0 : cur_k_ff;
         sw_start_ff <= cmd.clr_init ? '0 : cur_k_ff;
         sw_end_ff   <= cmd.clr_init ? '0 : cur_k_ff;
         sw_val_ff   <= cmd.clr_init || op_ff;
         sw_clr_ff   <= cmd.clr_init;
      end else if (cmd.sweep_step) begin
         if (sw_pos_ff == sw_end_ff) begin
            if (sw_lvl_ff != LVL_W'(TREE_LEVELS)) begin
               sw_lvl_ff   <= sw_lvl_ff + LVL_W'(1);
               sw_start_ff <= sw_start_ff << 1;
               sw_pos_ff   <= sw_start_ff << 1;
               sw_end_ff   <= (sw_end_ff << 1) | POS_W'(1);
            end
         end else begin
            sw_pos_ff <= sw_pos_ff + POS_W'(1);
         end
      end
   end

   // path walk
   always_ff @(posedge clock) begin
      if (cmd.hit) begin
         up_lvl_ff <= cur_lvl_ff;
         up_k_ff   <= cur_k_ff;
         up_val_ff <= op_ff;
      end else if (cmd.up_step) begin
         up_lvl_ff <= up_lvl_ff - LVL_W'(1);
         up_k_ff   <= up_k_ff >> 1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ok_ff   <= cmd.rsp_ok;
         rsp_addr_ff <= (cmd.rsp_ok && !op_ff) ? alloc_addr : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_success        = rsp_ok_ff;

   // status
   always_comb begin
      stat.op_free    = op_ff;
      stat.size_fail  = size_fail_ff;
      stat.addr_fail  = diff_ff[ADDR_W-1:REGION_SHIFT] != '0;
      stat.match      = op_ff ? (aligned && ah_rd_ff) : nf_rd_ff;
      stat.scan_last  = op_ff ? (cur_lvl_ff == LVL_W'(TREE_LEVELS))
                              : (cur_k_ff == POS_W'((1 << cur_lvl_ff) - 1));
      stat.sweep_last = (sw_pos_ff == sw_end_ff) && (sw_lvl_ff == LVL_W'(TREE_LEVELS));
      stat.up_top     = up_lvl_ff == '0;
      stat.sib_free   = nf_rd_ff;
      stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   // checks on the datapath
   `BTA_ASSERT_IMP(a_no_rsp_overwrite, clock, reset, cmd.load_rsp, !(rsp_valid_ff && !rsp_ready), "result overwritten before taken")
   `BTA_ASSERT_IMP(a_up_not_past_root, clock, reset, cmd.up_step, up_lvl_ff != '0, "path walk above the root")
   `BTA_ASSERT_IMP(a_sweep_in_tree, clock, reset, cmd.sweep_step, sw_lvl_ff <= LVL_W'(TREE_LEVELS) && sw_pos_ff <= sw_end_ff, "sweep outside the tree")

endmodule

// ===== rtl/buddy_tree_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_tree_allocator
// binary buddy allocator over a 1 MiB region of 64-byte leaves
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  req_op, req_request_bytes, req_block_address
// rsp      out        rsp_valid/rsp_ready  rsp_result_address, rsp_success
// csr      in         csr_wr_en            csr_wr_data (region base)
//
// one transaction at a time; allocate scans its target level node by node,
// then sweeps the taken subtree node by node and marks the path level by level
// free checks up to 15 candidate levels, sweeps the subtree, then
// coalesces level by level while the sibling is free
// after reset a clearing pass over all 32767 nodes runs before req_ready rises
// a finished result waits in the output register; a stalled rsp holds the next done
// ----------------------------------------------------------------------------
module buddy_tree_allocator import bta_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [ADDR_W-1:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [SIZE_W-1:0] req_request_bytes,
   input  logic [ADDR_W-1:0] req_block_address,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_result_address,
   output logic              rsp_success
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   bta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // tree stores and registers
   bta_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_op             (req_op),
      .req_request_bytes  (req_request_bytes),
      .req_block_address  (req_block_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_address (rsp_result_address),
      .rsp_success        (rsp_success)
   );

endmodule
